FILE: rtl/mal_pkg.sv
// Package for the motion activity level block: widths, constants, the
// controller command and status structs and the sample magnitude function.
// No dependencies.
`timescale 1ns / 1ps

package mal_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W = 16;
  localparam int FRAC_BITS = 16;
  localparam int NUM_AXES = 6;

  localparam int MAG_W = SAMPLE_W + 1;
  localparam int MOV_W = SAMPLE_W + 2;
  localparam int SUM_W = MOV_W + COUNT_W;
  localparam int PROD_W = MOV_W + COUNT_W;
  localparam int TWICE_W = SUM_W + 1;
  localparam int LEVEL_W = FRAC_BITS + 1;
  localparam int STEP_W = $clog2(FRAC_BITS);

  localparam int IN_DATA_W = ((NUM_AXES * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = LEVEL_W + 2;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COUNT_W-1:0] CALIB_RESET = COUNT_W'(100);

  localparam logic OP_CALIB = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
    logic cmp;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_meas;
    logic div_need;
    logic div_last;
  } sts_t;

  function automatic logic [MAG_W-1:0] mag_f(input logic [SAMPLE_W-1:0] x);
    logic [MAG_W-1:0] ext;
    ext = {x[SAMPLE_W-1], x};
    return x[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
  endfunction

endpackage

FILE: rtl/motion_activity_level.sv
// Top level of the motion activity level block: configuration register,
// controller and datapath. Depends on mal_pkg, mal_ctrl and mal_dp.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_tvalid/in_tready   | tdata: six axis samples, tuser: opcode
//   out_    | output    | out_tvalid/out_tready | tdata: level, ready_res, calib_done
//   cfg_    | input     | APB, pready always 1  | calib_samples at byte address 0
//
// A calibration request goes from acceptance through execution to a loaded
// result; a measurement request adds a compare state and, if needed, the
// one-bit-per-cycle fraction divider (16 steps). Requests are worked on one at
// a time; a new request is accepted while the previous result still waits in
// the output register. A result that is not taken holds the block before the
// result load. Reset is synchronous, active low, and clears calibration state.
`timescale 1ns / 1ps

module motion_activity_level (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // From bit 0: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z.
  input  logic [mal_pkg::IN_DATA_W-1:0]     in_tdata,
  // Bit 0: opcode.
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // From bit 0: level (17 bits), ready_res, calib_done, zero fill.
  output logic [mal_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mal_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [mal_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [mal_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [mal_pkg::COUNT_W-1:0] calib_r;
  logic                        reg_sel;
  mal_pkg::cmd_t               cmd;
  mal_pkg::sts_t               sts;
  logic [mal_pkg::LEVEL_W-1:0] level;
  logic                        ready_res;
  logic                        calib_done;

  assign cfg_pready = 1'b1;
  assign reg_sel = !cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= mal_pkg::CALIB_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      calib_r <= cfg_pwdata[mal_pkg::COUNT_W-1:0];
    end
  end

  assign cfg_prdata = reg_sel ? mal_pkg::CFG_DATA_W'(calib_r) : '0;

  mal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mal_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .calib_samples  (calib_r),
    .in_data        (in_tdata),
    .in_opcode      (in_tuser[0]),
    .out_level      (level),
    .out_ready_res  (ready_res),
    .out_calib_done (calib_done)
  );

  assign out_tdata = mal_pkg::OUT_DATA_W'({calib_done, ready_res, level});

endmodule

FILE: rtl/mal_ctrl.sv
// Controller state machine for the motion activity level block.
// Depends on mal_pkg for the command and status structs.
`timescale 1ns / 1ps

module mal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  mal_pkg::sts_t sts,
  output mal_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = sts.is_meas ? S_CMP : S_FIN;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        state_nxt = sts.div_need ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_EXEC)
    else $error("accepted request did not start execution");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> state_r == S_FIN)
    else $error("division did not finish after its last step");

endmodule

FILE: rtl/mal_dp.sv
// Datapath for the motion activity level block: movement sum, calibration
// state, baseline multiply and the bit-serial fraction divider.
// Depends on mal_pkg; driven by mal_ctrl through cmd_t and sts_t.
`timescale 1ns / 1ps

module mal_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mal_pkg::cmd_t                         cmd,
  output mal_pkg::sts_t                         sts,
  input  logic [mal_pkg::COUNT_W-1:0]           calib_samples,
  input  logic [mal_pkg::IN_DATA_W-1:0]         in_data,
  input  logic                                  in_opcode,
  output logic [mal_pkg::LEVEL_W-1:0]           out_level,
  output logic                                  out_ready_res,
  output logic                                  out_calib_done
);

  logic [mal_pkg::MOV_W-1:0]   mov_comb;
  logic [mal_pkg::MOV_W-1:0]   mov_r;
  logic                        op_r;

  logic [mal_pkg::SUM_W-1:0]   rsum_r;
  logic [mal_pkg::COUNT_W-1:0] rcount_r;
  logic [mal_pkg::SUM_W-1:0]   bsum_r;
  logic [mal_pkg::COUNT_W-1:0] bcount_r;
  logic                        calibrated_r;
  logic                        done_r;

  logic [mal_pkg::PROD_W-1:0]  prod_r;
  logic [mal_pkg::TWICE_W-1:0] rem_r;
  logic [mal_pkg::LEVEL_W-1:0] level_r;
  logic [mal_pkg::STEP_W-1:0]  step_r;

  logic [mal_pkg::LEVEL_W-1:0] out_level_r;
  logic                        out_ready_r;
  logic                        out_done_r;

  logic [mal_pkg::SUM_W-1:0]   sum_new;
  logic [mal_pkg::COUNT_W-1:0] cnt_new;
  logic                        complete;

  logic [mal_pkg::TWICE_W-1:0] twice;
  logic [mal_pkg::PROD_W-1:0]  diff;
  logic [mal_pkg::LEVEL_W-1:0] early_level;
  logic                        div_need;

  logic [mal_pkg::TWICE_W:0]   rem_sh;
  logic                        rem_ge;

  always_comb begin
    mov_comb = '0;
    for (int i = 0; i < mal_pkg::NUM_AXES; i++) begin
      mov_comb = mov_comb + mal_pkg::MOV_W'(
        mal_pkg::mag_f(in_data[i*mal_pkg::SAMPLE_W +: mal_pkg::SAMPLE_W]));
    end
  end

  always_comb begin
    sum_new = rsum_r + mal_pkg::SUM_W'(mov_r);
    cnt_new = (rcount_r != mal_pkg::COUNT_MAX) ? rcount_r + mal_pkg::COUNT_W'(1) : rcount_r;
    complete = (cnt_new >= calib_samples) || (cnt_new == mal_pkg::COUNT_MAX);
  end

  always_comb begin
    twice = {bsum_r, 1'b0};
    diff = prod_r - bsum_r;
    div_need = 1'b0;
    early_level = '0;
    if (!calibrated_r) begin
      early_level = '0;
    end else if (bsum_r == '0) begin
      early_level = (mov_r != '0) ? mal_pkg::LEVEL_ONE : '0;
    end else if (prod_r <= bsum_r) begin
      early_level = '0;
    end else if (mal_pkg::TWICE_W'(diff) >= twice) begin
      early_level = mal_pkg::LEVEL_ONE;
    end else begin
      div_need = 1'b1;
    end
  end

  always_comb begin
    rem_sh = {rem_r, 1'b0};
    rem_ge = rem_sh >= {1'b0, twice};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsum_r <= '0;
      rcount_r <= '0;
      bsum_r <= '0;
      bcount_r <= '0;
      calibrated_r <= 1'b0;
    end else if (cmd.exec && op_r == mal_pkg::OP_CALIB) begin
      if (complete) begin
        bsum_r <= sum_new;
        bcount_r <= cnt_new;
        calibrated_r <= 1'b1;
        rsum_r <= '0;
        rcount_r <= '0;
      end else begin
        rsum_r <= sum_new;
        rcount_r <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mov_r <= mov_comb;
      op_r <= in_opcode;
    end
    if (cmd.exec) begin
      prod_r <= mal_pkg::PROD_W'(mov_r) * mal_pkg::PROD_W'(bcount_r);
      done_r <= (op_r == mal_pkg::OP_CALIB) && complete;
      level_r <= '0;
    end
    if (cmd.cmp) begin
      level_r <= early_level;
      rem_r <= mal_pkg::TWICE_W'(diff);
      step_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? mal_pkg::TWICE_W'(rem_sh - {1'b0, twice})
                      : mal_pkg::TWICE_W'(rem_sh);
      level_r <= {level_r[mal_pkg::LEVEL_W-2:0], rem_ge};
      step_r <= step_r + mal_pkg::STEP_W'(1);
    end
    if (cmd.out_load) begin
      out_level_r <= level_r;
      out_ready_r <= calibrated_r;
      out_done_r <= done_r;
    end
  end

  assign sts.is_meas = (op_r == mal_pkg::OP_MEASURE);
  assign sts.div_need = div_need;
  assign sts.div_last = (step_r == mal_pkg::STEP_W'(mal_pkg::FRAC_BITS - 1));

  assign out_level = out_level_r;
  assign out_ready_res = out_ready_r;
  assign out_calib_done = out_done_r;

  a_calib_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == mal_pkg::OP_CALIB && complete) |=> calibrated_r)
    else $error("completed calibration not marked");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_level_r <= mal_pkg::LEVEL_ONE)
    else $error("level above one");

  a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (!out_done_r || out_ready_r))
    else $error("calibration done without ready flag");

endmodule
